[src/rotated_mono_rect_raster_unit_defines.svh]
// Assertion macros for the rotated monochrome rectangle raster unit.
`ifndef ROTATED_MONO_RECT_RASTER_UNIT_DEFINES_SVH
`define ROTATED_MONO_RECT_RASTER_UNIT_DEFINES_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define RMRR_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define RMRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/rmrr_pkg.sv]
// Shared constants, command codes and sequencer states of the raster unit.
package rmrr_pkg;

   localparam int LOGICAL_WIDTH  = 480;
   localparam int LOGICAL_HEIGHT = 800;
   localparam int NATIVE_WIDTH   = LOGICAL_HEIGHT;
   localparam int STRIDE_BYTES   = (NATIVE_WIDTH + 7) / 8;
   localparam int STORE_BYTES    = STRIDE_BYTES * LOGICAL_WIDTH;

   localparam int ADDR_W  = $clog2(STORE_BYTES);
   localparam int XW      = $clog2(LOGICAL_WIDTH);
   localparam int YW      = $clog2(LOGICAL_HEIGHT);
   localparam int CW      = 14;
   localparam int FIELD_W = 13;

   localparam logic signed [CW-1:0] X_MAX = CW'(LOGICAL_WIDTH - 1);
   localparam logic signed [CW-1:0] Y_MAX = CW'(LOGICAL_HEIGHT - 1);
   localparam logic [XW-1:0] X_LAST = XW'(LOGICAL_WIDTH - 1);
   localparam logic [YW-1:0] Y_LAST = YW'(LOGICAL_HEIGHT - 1);
   localparam logic [YW-1:0] NX_LAST = YW'(NATIVE_WIDTH - 1);
   localparam logic [ADDR_W-1:0] STORE_LAST = ADDR_W'(STORE_BYTES - 1);

   localparam logic [7:0] PIXEL_MSB  = 8'h80;
   localparam logic [7:0] FILL_WHITE = 8'hFF;
   localparam logic [7:0] FILL_BLACK = 8'h00;

   localparam logic [1:0] BOX_TOP    = 2'd0;
   localparam logic [1:0] BOX_BOTTOM = 2'd1;
   localparam logic [1:0] BOX_LEFT   = 2'd2;
   localparam logic [1:0] BOX_RIGHT  = 2'd3;

   typedef enum logic [2:0] {
      FUNC_CLEAR   = 3'd0,
      FUNC_PIXEL   = 3'd1,
      FUNC_OUTLINE = 3'd2,
      FUNC_FILL    = 3'd3,
      FUNC_READ    = 3'd4
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SETUP,
      ST_WALK,
      ST_DRAIN,
      ST_CLEAR,
      ST_READ_WAIT,
      ST_RESP
   } state_type;

endpackage

[src/rmrr_ram.sv]
// Generic simple dual-port RAM with one write port and a registered read port.
module rmrr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/rotated_mono_rect_raster_unit.sv]
// Top level of the rotated monochrome rectangle raster unit.
//
// Drawing engine over a 1-bit-per-pixel frame store of 48000 bytes held in one
// RAM (registered read). Logical pixel (x, y) of the 480x800 portrait canvas
// sits at byte x*100 + (799-y)/8, bit 7-((799-y)%8). One transaction runs at a
// time. Drawing commands clip every primitive to the canvas and then walk the
// visible pixels with one read-modify-write per cycle within each clipped box,
// a pipelined RAM access with forwarding of the previous write. An outline
// walks its four clipped edges in turn; a clear writes one byte per cycle.
// Reading bytes never written since reset returns undefined data, so clear the
// store first.
`include "rotated_mono_rect_raster_unit_defines.svh"

module rotated_mono_rect_raster_unit import rmrr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [2:0]                req_func,
   input  logic signed [FIELD_W-1:0] req_x_pos,
   input  logic signed [FIELD_W-1:0] req_y_pos,
   input  logic signed [FIELD_W-1:0] req_rect_width,
   input  logic signed [FIELD_W-1:0] req_rect_height,
   input  logic                      req_ink_black,
   input  logic [15:0]               req_byte_address,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [7:0]                rsp_read_data,
   output logic                      rsp_ignored
);

   state_type state_ff, state_in;

   func_type                   func_ff, func_in;
   logic signed [FIELD_W-1:0]  x_ff, x_in, y_ff, y_in, w_ff, w_in, h_ff, h_in;
   logic                       ink_ff, ink_in;
   logic [15:0]                baddr_ff, baddr_in;

   logic [1:0]                 box_ff, box_in;
   logic [XW-1:0]              c0_ff, c0_in, c1_ff, c1_in, cur_x_ff, cur_x_in;
   logic [YW-1:0]              r1_ff, r1_in, cur_y_ff, cur_y_in;
   logic [ADDR_W-1:0]          clr_cnt_ff, clr_cnt_in;

   logic                       s2_valid_ff, s2_valid_in;
   logic [ADDR_W-1:0]          s2_addr_ff, s2_addr_in;
   logic [7:0]                 s2_mask_ff, s2_mask_in;
   logic                       wr_valid_ff, wr_valid_in;
   logic [ADDR_W-1:0]          wr_addr_ff, wr_addr_in;
   logic [7:0]                 wr_data_ff, wr_data_in;

   logic [7:0]                 res_data_ff, res_data_in;
   logic                       res_ign_ff, res_ign_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_data_ff, rsp_data_in;
   logic                       rsp_ign_ff, rsp_ign_in;

   logic signed [CW-1:0]       xs, ys, xe1, ye1;
   logic signed [CW-1:0]       lo_c, hi_c, lo_r, hi_r, clo_c, chi_c, clo_r, chi_r;
   logic                       box_empty, box_last, off_canvas;
   logic [YW-1:0]              nx;
   logic [ADDR_W-1:0]          pix_addr;
   logic [7:0]                 pix_mask;
   logic [7:0]                 old_byte, new_byte;

   logic                       ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0]          ram_wr_addr, ram_rd_addr;
   logic [7:0]                 ram_wr_data, ram_rd_data;

   rmrr_ram #(
      .WIDTH (8),
      .DEPTH (STORE_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Box geometry and clipping
   always_comb begin
      xs  = CW'(x_ff);
      ys  = CW'(y_ff);
      xe1 = CW'(x_ff) + CW'(w_ff) - CW'(1);
      ye1 = CW'(y_ff) + CW'(h_ff) - CW'(1);
      lo_c = xs;
      hi_c = xe1;
      lo_r = ys;
      hi_r = ye1;
      case (func_ff)
         FUNC_PIXEL: begin
            hi_c = xs;
            hi_r = ys;
         end
         FUNC_OUTLINE: begin
            case (box_ff)
               BOX_TOP: hi_r = ys;
               BOX_BOTTOM: lo_r = ye1;
               BOX_LEFT: hi_c = xs;
               default: lo_c = xe1;
            endcase
         end
         default: ;
      endcase
      clo_c = (lo_c < 0) ? '0 : lo_c;
      chi_c = (hi_c > X_MAX) ? X_MAX : hi_c;
      clo_r = (lo_r < 0) ? '0 : lo_r;
      chi_r = (hi_r > Y_MAX) ? Y_MAX : hi_r;
      box_empty  = (clo_c > chi_c) || (clo_r > chi_r);
      box_last   = (func_ff != FUNC_OUTLINE) || (box_ff == BOX_RIGHT);
      off_canvas = (xs < 0) || (xs > X_MAX) || (ys < 0) || (ys > Y_MAX);
   end

   // Pixel address and read-modify-write stage
   always_comb begin
      nx       = NX_LAST - cur_y_ff;
      pix_addr = ADDR_W'(cur_x_ff) * ADDR_W'(STRIDE_BYTES) + ADDR_W'(nx >> 3);
      pix_mask = PIXEL_MSB >> nx[2:0];
      old_byte = (wr_valid_ff && (wr_addr_ff == s2_addr_ff)) ? wr_data_ff : ram_rd_data;
      new_byte = ink_ff ? (old_byte & ~s2_mask_ff) : (old_byte | s2_mask_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      w_in        = w_ff;
      h_in        = h_ff;
      ink_in      = ink_ff;
      baddr_in    = baddr_ff;
      box_in      = box_ff;
      c0_in       = c0_ff;
      c1_in       = c1_ff;
      r1_in       = r1_ff;
      cur_x_in    = cur_x_ff;
      cur_y_in    = cur_y_ff;
      clr_cnt_in  = clr_cnt_ff;
      res_data_in = res_data_ff;
      res_ign_in  = res_ign_ff;
      s2_valid_in = 1'b0;
      s2_addr_in  = pix_addr;
      s2_mask_in  = pix_mask;
      ram_rd_en   = 1'b0;
      ram_rd_addr = pix_addr;
      ram_wr_en   = s2_valid_ff;
      ram_wr_addr = s2_addr_ff;
      ram_wr_data = new_byte;
      wr_valid_in = s2_valid_ff;
      wr_addr_in  = s2_addr_ff;
      wr_data_in  = new_byte;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      rsp_ign_in   = rsp_ign_ff;
      req_stall    = (state_ff != ST_IDLE);

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in  = func_type'(req_func);
               x_in     = req_x_pos;
               y_in     = req_y_pos;
               w_in     = req_rect_width;
               h_in     = req_rect_height;
               ink_in   = req_ink_black;
               baddr_in = req_byte_address;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            res_data_in = '0;
            res_ign_in  = 1'b0;
            box_in      = BOX_TOP;
            clr_cnt_in  = '0;
            unique case (func_ff) inside
               FUNC_CLEAR: state_in = ST_CLEAR;
               FUNC_PIXEL: begin
                  res_ign_in = off_canvas;
                  state_in   = ST_SETUP;
               end
               FUNC_OUTLINE, FUNC_FILL: begin
                  if ((w_ff <= 0) || (h_ff <= 0)) begin
                     res_ign_in = 1'b1;
                     state_in   = ST_RESP;
                  end else begin
                     state_in = ST_SETUP;
                  end
               end
               FUNC_READ: begin
                  if (32'(baddr_ff) < 32'(STORE_BYTES)) begin
                     ram_rd_en   = 1'b1;
                     ram_rd_addr = ADDR_W'(baddr_ff);
                     state_in    = ST_READ_WAIT;
                  end else begin
                     res_ign_in = 1'b1;
                     state_in   = ST_RESP;
                  end
               end
               default: begin
                  res_ign_in = 1'b1;
                  state_in   = ST_RESP;
               end
            endcase
         end
         ST_SETUP: begin
            c0_in    = XW'(clo_c);
            c1_in    = XW'(chi_c);
            r1_in    = YW'(chi_r);
            cur_x_in = XW'(clo_c);
            cur_y_in = YW'(clo_r);
            if (!box_empty) begin
               state_in = ST_WALK;
            end else if (box_last) begin
               state_in = ST_DRAIN;
            end else begin
               box_in = box_ff + 2'd1;
            end
         end
         ST_WALK: begin
            ram_rd_en   = 1'b1;
            s2_valid_in = 1'b1;
            if (cur_x_ff != c1_ff) begin
               cur_x_in = cur_x_ff + XW'(1);
            end else if (cur_y_ff != r1_ff) begin
               cur_x_in = c0_ff;
               cur_y_in = cur_y_ff + YW'(1);
            end else if (box_last) begin
               state_in = ST_DRAIN;
            end else begin
               box_in   = box_ff + 2'd1;
               state_in = ST_SETUP;
            end
         end
         ST_DRAIN: state_in = ST_RESP;
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_cnt_ff;
            ram_wr_data = ink_ff ? FILL_BLACK : FILL_WHITE;
            wr_valid_in = 1'b0;
            clr_cnt_in  = clr_cnt_ff + ADDR_W'(1);
            if (clr_cnt_ff == STORE_LAST) begin
               state_in = ST_RESP;
            end
         end
         ST_READ_WAIT: begin
            res_data_in = ram_rd_data;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_data_ff;
               rsp_ign_in   = res_ign_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      w_ff        <= w_in;
      h_ff        <= h_in;
      ink_ff      <= ink_in;
      baddr_ff    <= baddr_in;
      box_ff      <= box_in;
      c0_ff       <= c0_in;
      c1_ff       <= c1_in;
      r1_ff       <= r1_in;
      cur_x_ff    <= cur_x_in;
      cur_y_ff    <= cur_y_in;
      clr_cnt_ff  <= clr_cnt_in;
      s2_addr_ff  <= s2_addr_in;
      s2_mask_ff  <= s2_mask_in;
      wr_addr_ff  <= wr_addr_in;
      wr_data_ff  <= wr_data_in;
      res_data_ff <= res_data_in;
      res_ign_ff  <= res_ign_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ign_ff  <= rsp_ign_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_ignored   = rsp_ign_ff;

   `RMRR_ASSERT_NOW(a_walk_on_canvas, clock, reset, state_ff == ST_WALK,
      (cur_x_ff <= X_LAST) && (cur_y_ff <= Y_LAST), "walk left the canvas")
   `RMRR_ASSERT_NOW(a_rmw_in_draw, clock, reset, s2_valid_ff,
      (state_ff == ST_WALK) || (state_ff == ST_SETUP) || (state_ff == ST_DRAIN),
      "pixel write outside drawing")
   `RMRR_ASSERT_NOW(a_clear_no_read, clock, reset, state_ff == ST_CLEAR,
      !ram_rd_en && !s2_valid_ff, "store access during clear")
   `RMRR_ASSERT_NEXT(a_clear_start, clock, reset,
      (state_ff == ST_DECODE) && (func_ff == FUNC_CLEAR),
      (state_ff == ST_CLEAR) && (clr_cnt_ff == '0), "clear did not start at zero")

endmodule
